>>> hw/rtl/matrix_vector_multiply_macros.svh
// ----------------------------------------------------------------------------
// matrix_vector_multiply_macros
// Assertion shorthands shared by the matrix-vector multiply RTL.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define MVM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared constants, types and arithmetic helpers for the matrix-vector multiply.
// ----------------------------------------------------------------------------
`default_nettype none

package mvm_pkg;

  // storage limits
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 16;

  localparam int COL_IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // configuration register width and port index width
  localparam int DIM_W     = 5;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

  // item modes
  localparam logic MODE_VECTOR = 1'b0;
  localparam logic MODE_MATRIX = 1'b1;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DIM_ERR = 1'b1;

  // control carried alongside a matrix item through the pipeline
  typedef struct packed {
    logic                 err;
    logic                 clear;
    logic                 last_col;
    logic [ROW_IDX_W-1:0] row_idx;
    logic                 last_row;
  } mvm_tag_t;

  // signed 64-bit add that saturates at the limits
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  // Q32.32 to Q16.16: floor shift by 16, then saturate to 32 bits
  function automatic logic signed [31:0] scale_q16(input logic signed [63:0] acc);
    logic signed [47:0] q;
    q = acc[63:16];
    if ((&q[47:31]) || !(|q[47:31])) begin
      scale_q16 = q[31:0];
    end else begin
      scale_q16 = q[47] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mvm_front.sv
// ----------------------------------------------------------------------------
// mvm_front
// Configuration registers, vector store and row/column tracking; registers
// each accepted matrix item with its vector operand and control tag.
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           item_valid,
  input  wire logic                           mode,
  input  wire logic signed [31:0]             operand_value,
  input  wire logic                           cfg_write,
  input  wire logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mvm_pkg::DIM_W-1:0]      cfg_data,
  output logic                                s1_valid,
  output logic signed [31:0]                  s1_x,
  output logic signed [31:0]                  s1_v,
  output mvm_pkg::mvm_tag_t                   s1_tag
);

  logic [mvm_pkg::DIM_W-1:0]     row_count;
  logic [mvm_pkg::DIM_W-1:0]     column_count;
  logic [mvm_pkg::COL_IDX_W-1:0] vector_load_index;
  logic [mvm_pkg::COL_IDX_W-1:0] column_position;
  logic [mvm_pkg::ROW_IDX_W-1:0] row_position;
  logic signed [31:0]            vstore [mvm_pkg::MAX_COLUMNS];

  logic [mvm_pkg::DIM_W-1:0]     rows_eff;
  logic [mvm_pkg::DIM_W-1:0]     cols_eff;
  logic                          accept;
  logic                          dim_err;
  logic [mvm_pkg::COL_IDX_W-1:0] vwr_idx;
  logic [mvm_pkg::DIM_W-1:0]     vwr_inc;
  logic [mvm_pkg::COL_IDX_W-1:0] vector_load_index_next;
  logic                          col_wrap;
  logic [mvm_pkg::COL_IDX_W-1:0] cpos;
  logic [mvm_pkg::ROW_IDX_W-1:0] rpos;
  logic [mvm_pkg::DIM_W-1:0]     cpos_inc;
  logic [mvm_pkg::DIM_W-1:0]     rpos_inc;
  logic                          last_col;
  logic                          last_row;
  logic [mvm_pkg::COL_IDX_W-1:0] column_position_next;
  logic [mvm_pkg::ROW_IDX_W-1:0] row_position_next;

  // dimensions clamped to the storage limits
  always_comb begin
    rows_eff = (row_count > mvm_pkg::DIM_W'(mvm_pkg::MAX_ROWS))
             ? mvm_pkg::DIM_W'(mvm_pkg::MAX_ROWS) : row_count;
    cols_eff = (column_count > mvm_pkg::DIM_W'(mvm_pkg::MAX_COLUMNS))
             ? mvm_pkg::DIM_W'(mvm_pkg::MAX_COLUMNS) : column_count;
  end

  assign accept  = item_valid && en;
  assign dim_err = (rows_eff == '0) || (cols_eff == '0);

  // vector load position
  always_comb begin
    if (cols_eff == '0 || mvm_pkg::DIM_W'(vector_load_index) >= cols_eff) begin
      vwr_idx = '0;
    end else begin
      vwr_idx = vector_load_index;
    end
    vwr_inc = mvm_pkg::DIM_W'(vwr_idx) + mvm_pkg::DIM_W'(1);
    if (cols_eff == '0 || vwr_inc >= cols_eff) begin
      vector_load_index_next = '0;
    end else begin
      vector_load_index_next = vwr_inc[mvm_pkg::COL_IDX_W-1:0];
    end
  end

  // matrix position, wrapping after a dimension change
  always_comb begin
    col_wrap = mvm_pkg::DIM_W'(column_position) >= cols_eff;
    cpos     = col_wrap ? '0 : column_position;
    rpos     = (mvm_pkg::DIM_W'(row_position) >= rows_eff) ? '0 : row_position;
    cpos_inc = mvm_pkg::DIM_W'(cpos) + mvm_pkg::DIM_W'(1);
    rpos_inc = mvm_pkg::DIM_W'(rpos) + mvm_pkg::DIM_W'(1);
    last_col = cpos_inc >= cols_eff;
    last_row = rpos_inc == rows_eff;
    if (last_col) begin
      column_position_next = '0;
      row_position_next    = (rpos_inc >= rows_eff) ? '0 : rpos_inc[mvm_pkg::ROW_IDX_W-1:0];
    end else begin
      column_position_next = cpos_inc[mvm_pkg::COL_IDX_W-1:0];
      row_position_next    = rpos;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= mvm_pkg::DIM_W'(1);
      column_count <= mvm_pkg::DIM_W'(1);
    end else if (cfg_write) begin
      if (cfg_index == mvm_pkg::REG_ROW_COUNT) begin
        row_count <= cfg_data;
      end else if (cfg_index == mvm_pkg::REG_COLUMN_COUNT) begin
        column_count <= cfg_data;
      end
    end
  end

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_load_index <= '0;
      column_position   <= '0;
      row_position      <= '0;
    end else if (accept) begin
      if (mode == mvm_pkg::MODE_VECTOR) begin
        vector_load_index <= vector_load_index_next;
      end else if (!dim_err) begin
        column_position <= column_position_next;
        row_position    <= row_position_next;
      end
    end
  end

  // vector store
  always_ff @(posedge clk) begin
    if (accept && mode == mvm_pkg::MODE_VECTOR) begin
      vstore[vwr_idx] <= operand_value;
    end
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid && (mode == mvm_pkg::MODE_MATRIX);
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_x            <= operand_value;
      s1_v            <= vstore[cpos];
      s1_tag.err      <= dim_err;
      s1_tag.clear    <= col_wrap;
      s1_tag.last_col <= last_col;
      s1_tag.row_idx  <= rpos;
      s1_tag.last_row <= last_row;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mvm_mac.sv
// ----------------------------------------------------------------------------
// mvm_mac
// Product register, saturating 64-bit accumulator and result register with
// the pipeline hold that follows the result stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_vector_multiply_macros.svh"

module mvm_mac (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s1_valid,
  input  wire logic signed [31:0]     s1_x,
  input  wire logic signed [31:0]     s1_v,
  input  wire mvm_pkg::mvm_tag_t      s1_tag,
  input  wire logic                   result_stall,
  output logic                        en,
  output logic                        result_valid,
  output logic signed [31:0]          product_element,
  output logic [3:0]                  row_index,
  output logic                        last_row,
  output logic                        status
);

  logic                s2_valid;
  logic signed [63:0]  s2_prod;
  mvm_pkg::mvm_tag_t   s2_tag;
  logic signed [63:0]  acc;
  logic signed [63:0]  acc_base;
  logic signed [63:0]  acc_sum;
  logic signed [63:0]  prod;

  // pipeline moves unless a finished result is held
  assign en = !(result_valid && result_stall);

  assign prod     = s1_x * s1_v;
  assign acc_base = s2_tag.clear ? '0 : acc;
  assign acc_sum  = mvm_pkg::sat_add64(acc_base, s2_prod);

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  // stage 2 product
  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod <= prod;
      s2_tag  <= s1_tag;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (en && s2_valid && !s2_tag.err) begin
      acc <= s2_tag.last_col ? '0 : acc_sum;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= s2_valid && (s2_tag.err || s2_tag.last_col);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_tag.err) begin
        product_element <= '0;
        row_index       <= '0;
        last_row        <= 1'b0;
        status          <= mvm_pkg::STATUS_DIM_ERR;
      end else begin
        product_element <= mvm_pkg::scale_q16(acc_sum);
        row_index       <= 4'(s2_tag.row_idx);
        last_row        <= s2_tag.last_row;
        status          <= mvm_pkg::STATUS_OK;
      end
    end
  end

  // checks
  `MVM_ASSERT_NOW(a_err_fields_zero, result_valid && status == mvm_pkg::STATUS_DIM_ERR, product_element == '0 && row_index == '0 && !last_row, "error result carries nonzero fields")
  `MVM_ASSERT_NEXT(a_hold_keeps_acc, !en, $stable(acc), "accumulator changed during hold")
  `MVM_ASSERT_NEXT(a_row_end_clears, en && s2_valid && !s2_tag.err && s2_tag.last_col, acc == '0, "accumulator not cleared after row")

endmodule

`default_nettype wire

>>> hw/rtl/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Streams y = A*x in signed Q16.16 with a saturating 64-bit accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (mode, operand_value) enter on item_valid / item_stall.
//   Mode 0 items load the stored vector, wrapping after min(column_count, 16)
//   entries; mode 1 items are matrix elements in row-major order.
//   A result item leaves on result_valid / result_stall once per completed
//   row, or once per matrix item when row_count or column_count is zero
//   (status set, other fields zero). Vector items produce no result.
//   The user writes registers (cfg_write/cfg_index/cfg_data) only while the
//   block is idle (unenforced). Index 0 is row_count, index 1 is column_count.
//   After a row's last element is accepted, its result passes the input
//   register, product register and result register.
//   Throughput: one item per cycle unless a stalled result holds the pipeline;
//   the accumulate step closes a loop on the accumulator register.
//   A stalled result freezes the whole pipeline and raises item_stall in the
//   same cycle.
//   Reset clears positions, the accumulator and all valid flags and sets both
//   dimensions to 1; vector entries hold no value until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_vector_multiply (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic                           mode,
  input  wire logic signed [31:0]             operand_value,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic signed [31:0]                  product_element,
  output logic [3:0]                          row_index,
  output logic                                last_row,
  output logic                                status,
  input  wire logic                           cfg_write,
  input  wire logic [mvm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mvm_pkg::DIM_W-1:0]      cfg_data
);

  logic               en;
  logic               s1_valid;
  logic signed [31:0] s1_x;
  logic signed [31:0] s1_v;
  mvm_pkg::mvm_tag_t  s1_tag;

  assign item_stall = !en;

  // positions, vector store and input register
  mvm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .item_valid    (item_valid),
    .mode          (mode),
    .operand_value (operand_value),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s1_valid      (s1_valid),
    .s1_x          (s1_x),
    .s1_v          (s1_v),
    .s1_tag        (s1_tag)
  );

  // multiply, accumulate and result register
  mvm_mac u_mac (
    .clk             (clk),
    .rst             (rst),
    .s1_valid        (s1_valid),
    .s1_x            (s1_x),
    .s1_v            (s1_v),
    .s1_tag          (s1_tag),
    .result_stall    (result_stall),
    .en              (en),
    .result_valid    (result_valid),
    .product_element (product_element),
    .row_index       (row_index),
    .last_row        (last_row),
    .status          (status)
  );

endmodule

`default_nettype wire
